>>> rtl/ttanf_pkg.sv
`default_nettype none

package ttanf_pkg;

  localparam int MAX_VARS    = 6;
  localparam int TABLE_W     = 64;
  localparam int VAR_CNT_W   = 3;
  localparam int ROW_IDX_W   = 6;
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = 1;
  localparam int QUEUE_CNT_W = 2;

  // Positions whose row-index bit b is clear.
  localparam logic [TABLE_W-1:0] BIT_CLEAR_MASK [MAX_VARS] = '{
    64'h5555555555555555,
    64'h3333333333333333,
    64'h0F0F0F0F0F0F0F0F,
    64'h00FF00FF00FF00FF,
    64'h0000FFFF0000FFFF,
    64'h00000000FFFFFFFF
  };

  // Monomials of degree zero or one.
  localparam logic [TABLE_W-1:0] LOW_DEGREE_MASK = 64'h0000000100010117;

  typedef struct packed {
    logic keeps_zero;
    logic keeps_one;
    logic self_dual;
    logic monotone;
    logic linear;
  } class_flags_t;

  // One classified function as it travels from the front to the back.
  typedef struct packed {
    logic [TABLE_W-1:0]   table_bits;
    logic [VAR_CNT_W-1:0] var_cnt;
    logic                 keeps_zero;
    logic                 keeps_one;
    logic                 last_fn;
  } entry_t;

endpackage

`default_nettype wire

>>> rtl/ttanf_front.sv
`default_nettype none

module ttanf_front (
  input  wire logic [ttanf_pkg::TABLE_W-1:0]   truth_table_i,
  input  wire logic [ttanf_pkg::VAR_CNT_W-1:0] var_count_i,
  input  wire logic                            last_function_i,
  output ttanf_pkg::entry_t                    entry_o
);
  import ttanf_pkg::*;

  logic [VAR_CNT_W-1:0] n_clamped;
  logic [TABLE_W-1:0]   live;
  logic [TABLE_W-1:0]   t_live;
  logic [ROW_IDX_W-1:0] top_row;

  always_comb begin
    if (var_count_i > VAR_CNT_W'(MAX_VARS)) begin
      n_clamped = VAR_CNT_W'(MAX_VARS);
    end else begin
      n_clamped = var_count_i;
    end
  end

  always_comb begin
    if (n_clamped >= VAR_CNT_W'(ROW_IDX_W)) begin
      live = '1;
    end else begin
      live = (TABLE_W'(1) << (7'(1) << n_clamped)) - TABLE_W'(1);
    end
  end

  assign t_live  = truth_table_i & live;
  assign top_row = ROW_IDX_W'((7'(1) << n_clamped) - 7'(1));

  always_comb begin
    entry_o.table_bits = t_live;
    entry_o.var_cnt    = n_clamped;
    entry_o.keeps_zero = ~t_live[0];
    entry_o.keeps_one  = t_live[top_row];
    entry_o.last_fn    = last_function_i;
  end

endmodule

`default_nettype wire

>>> rtl/ttanf_queue.sv
`default_nettype none

module ttanf_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire ttanf_pkg::entry_t push_data_i,
  output logic                   not_full_o,
  input  wire logic              pop_i,
  output logic                   not_empty_o,
  output ttanf_pkg::entry_t      pop_data_o
);
  import ttanf_pkg::*;

  entry_t                 slot_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QUEUE_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QUEUE_CNT_W-1:0] count_q, count_d;

  assign not_full_o  = count_q != QUEUE_CNT_W'(QUEUE_DEPTH);
  assign not_empty_o = count_q != '0;
  assign pop_data_o  = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + QUEUE_PTR_W'(1) : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + QUEUE_PTR_W'(1) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + QUEUE_CNT_W'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - QUEUE_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

>>> rtl/ttanf_back.sv
`default_nettype none

module ttanf_back (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          entry_valid_i,
  input  wire ttanf_pkg::entry_t             entry_i,
  output logic                               entry_pop_o,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [ttanf_pkg::TABLE_W-1:0]      anf_coeffs_o,
  output ttanf_pkg::class_flags_t            flags_o,
  output logic                               system_complete_o
);
  import ttanf_pkg::*;

  logic [TABLE_W-1:0] anf;
  logic               monotone;
  logic               self_dual;
  logic [MAX_VARS:0]  sd_by_n;
  class_flags_t       flags;
  class_flags_t       acc_q, acc_d;
  class_flags_t       acc_and;
  logic               complete;

  logic               out_valid_q;
  logic [TABLE_W-1:0] anf_q;
  class_flags_t       flags_q;
  logic               complete_q;

  // Moebius transform, one butterfly layer per variable in use.
  always_comb begin
    anf = entry_i.table_bits;
    for (int b = 0; b < MAX_VARS; b++) begin
      if (VAR_CNT_W'(b) < entry_i.var_cnt) begin
        anf = anf ^ ((anf & BIT_CLEAR_MASK[b]) << (1 << b));
      end
    end
  end

  // A violation is a row with bit b clear where f is 1 but f of the raised row is 0.
  always_comb begin
    monotone = 1'b1;
    for (int b = 0; b < MAX_VARS; b++) begin
      if (VAR_CNT_W'(b) < entry_i.var_cnt) begin
        if ((entry_i.table_bits & BIT_CLEAR_MASK[b]
             & ~(entry_i.table_bits >> (1 << b))) != '0) begin
          monotone = 1'b0;
        end
      end
    end
  end

  // Self-duality for every possible variable count, then pick the live one.
  // With no variables the single row is its own complement, so it never passes.
  always_comb begin
    logic [ROW_IDX_W-1:0] mirror;
    for (int k = 0; k <= MAX_VARS; k++) begin
      sd_by_n[k] = 1'b1;
      for (int r = 0; r < TABLE_W; r++) begin
        mirror = ROW_IDX_W'(r) ^ ROW_IDX_W'((1 << k) - 1);
        if (r < (1 << k)) begin
          if (entry_i.table_bits[r] == entry_i.table_bits[mirror]) begin
            sd_by_n[k] = 1'b0;
          end
        end
      end
    end
  end

  assign self_dual = sd_by_n[entry_i.var_cnt];

  always_comb begin
    flags.keeps_zero = entry_i.keeps_zero;
    flags.keeps_one  = entry_i.keeps_one;
    flags.self_dual  = self_dual;
    flags.monotone   = monotone;
    flags.linear     = (anf & ~LOW_DEGREE_MASK) == '0;
  end

  assign entry_pop_o = entry_valid_i && (!out_valid_q || out_ready_i);

  always_comb begin
    acc_and  = acc_q & flags;
    complete = entry_i.last_fn && (acc_and == '0);
    acc_d    = acc_q;
    if (entry_pop_o) begin
      acc_d = entry_i.last_fn ? '1 : acc_and;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '1;
      out_valid_q <= 1'b0;
    end else begin
      acc_q <= acc_d;
      if (entry_pop_o) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (entry_pop_o) begin
      anf_q      <= anf;
      flags_q    <= flags;
      complete_q <= complete;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign anf_coeffs_o      = anf_q;
  assign flags_o           = flags_q;
  assign system_complete_o = complete_q;

endmodule

`default_nettype wire

>>> rtl/truth_table_anf_post_classes.sv
`default_nettype none

// Boolean function analyzer. Each request carries a truth table of up to six
// variables; the result gives the ANF coefficients and the five Post class flags
// of that function, and on a request marked last_function also whether the
// system of functions since the previous last one is functionally complete.
// The front masks the table and clamps the variable count, a two-entry queue
// decouples it from the back, and the back runs the Moebius transform and class
// checks combinationally into an output register. One request is taken every
// clock while in_ready_o is high; its result is registered first in the queue and
// then in the output register. While the output is stalled the output register
// and the queue hold up to three requests before in_ready_o drops.
module truth_table_anf_post_classes (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic [ttanf_pkg::TABLE_W-1:0]   truth_table_i,
  input  wire logic [ttanf_pkg::VAR_CNT_W-1:0] var_count_i,
  input  wire logic                            last_function_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic [ttanf_pkg::TABLE_W-1:0]        anf_coeffs_o,
  output logic                                 keeps_zero_o,
  output logic                                 keeps_one_o,
  output logic                                 self_dual_o,
  output logic                                 monotone_o,
  output logic                                 linear_o,
  output logic                                 system_complete_o
);
  import ttanf_pkg::*;

  entry_t       front_entry;
  entry_t       head_entry;
  logic         q_not_full;
  logic         q_not_empty;
  logic         q_pop;
  class_flags_t flags;

  ttanf_front u_front (
    .truth_table_i   (truth_table_i),
    .var_count_i     (var_count_i),
    .last_function_i (last_function_i),
    .entry_o         (front_entry)
  );

  ttanf_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_valid_i && q_not_full),
    .push_data_i (front_entry),
    .not_full_o  (q_not_full),
    .pop_i       (q_pop),
    .not_empty_o (q_not_empty),
    .pop_data_o  (head_entry)
  );

  ttanf_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .entry_valid_i     (q_not_empty),
    .entry_i           (head_entry),
    .entry_pop_o       (q_pop),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .anf_coeffs_o      (anf_coeffs_o),
    .flags_o           (flags),
    .system_complete_o (system_complete_o)
  );

  assign in_ready_o   = q_not_full;
  assign keeps_zero_o = flags.keeps_zero;
  assign keeps_one_o  = flags.keeps_one;
  assign self_dual_o  = flags.self_dual;
  assign monotone_o   = flags.monotone;
  assign linear_o     = flags.linear;

endmodule

`default_nettype wire
